// ===== hw/rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Command frame deframer package
// Shared types, codes and the length decode used by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ID_W     = 2;
   localparam int unsigned EP_W     = 2;
   localparam int unsigned LEN_W    = 8;
   localparam int unsigned IDX_W    = 7;
   localparam int unsigned KIND_W   = 2;

   localparam logic [EP_W-1:0]   OWN_EP_RESET = 2'd2;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD  = 8'd128;

   localparam logic [BYTE_W-1:0] HDR_VERSION_MASK  = 8'h80;
   localparam logic [BYTE_W-1:0] HDR_RESERVED_MASK = 8'h04;

   typedef enum logic [KIND_W-1:0] {
      KIND_HDR_OK  = 2'd0,
      KIND_HDR_BAD = 2'd1,
      KIND_PAYLOAD = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTE_W-1:0]     payload_byte;
      logic [ID_W-1:0]       frame_id;
      logic [EP_W-1:0]       frame_endpoint;
      logic [LEN_W-1:0]      payload_length;
      logic [IDX_W-1:0]      byte_index;
      logic                  last;
      logic                  for_us;
   } rsp_type;

   function automatic logic [LEN_W-1:0] len_decode(input logic [1:0] code);
      logic [LEN_W-1:0] len;
      unique case (code)
         2'd0: len = 8'd1;
         2'd1: len = 8'd4;
         2'd2: len = 8'd32;
         2'd3: len = MAX_PAYLOAD;
         default: len = 8'd1;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Command frame deframer input stage
// Registers each received byte and its valid flag ahead of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [cfd_pkg::BYTE_W-1:0] req_rx_byte,
   input  wire logic                      advance,
   output logic                           s1_valid,
   output logic [cfd_pkg::BYTE_W-1:0]     s1_byte
);
   import cfd_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_byte  = byte_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cfd_decode.sv =====
// ----------------------------------------------------------------------------
// Command frame deframer decoder
// Checks headers, tracks the frame state and forms one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_decode (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [cfd_pkg::BYTE_W-1:0] rx_byte,
   input  wire logic [cfd_pkg::EP_W-1:0]   own_endpoint,
   output cfd_pkg::rsp_type                rsp
);
   import cfd_pkg::*;

   logic              in_payload_ff, in_payload_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [EP_W-1:0]   ep_ff, ep_in;
   logic              hdr_bad;
   logic              is_last;
   logic [ID_W-1:0]   hdr_id;
   logic [EP_W-1:0]   hdr_ep;
   logic [LEN_W-1:0]  hdr_len;

   assign hdr_bad = ((rx_byte & HDR_VERSION_MASK) != '0) ||
                    ((rx_byte & HDR_RESERVED_MASK) != '0);
   assign hdr_id  = rx_byte[6:5];
   assign hdr_ep  = rx_byte[4:3];
   assign hdr_len = len_decode(rx_byte[1:0]);
   assign is_last = ({1'b0, count_ff} + 8'd1) >= len_ff;

   always_comb begin
      in_payload_in = in_payload_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      id_in         = id_ff;
      ep_in         = ep_ff;
      rsp           = '0;
      if (!in_payload_ff) begin
         if (hdr_bad) begin
            rsp.kind = KIND_HDR_BAD;
         end else begin
            id_in              = hdr_id;
            ep_in              = hdr_ep;
            len_in             = hdr_len;
            count_in           = '0;
            in_payload_in      = 1'b1;
            rsp.kind           = KIND_HDR_OK;
            rsp.frame_id       = hdr_id;
            rsp.frame_endpoint = hdr_ep;
            rsp.payload_length = hdr_len;
            rsp.for_us         = (hdr_ep == own_endpoint);
         end
      end else begin
         rsp.kind           = KIND_PAYLOAD;
         rsp.payload_byte   = rx_byte;
         rsp.frame_id       = id_ff;
         rsp.frame_endpoint = ep_ff;
         rsp.payload_length = len_ff;
         rsp.byte_index     = count_ff;
         rsp.last           = is_last;
         rsp.for_us         = (ep_ff == own_endpoint);
         if (is_last) begin
            in_payload_in = 1'b0;
            count_in      = '0;
         end else begin
            count_in = count_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         count_ff      <= '0;
         len_ff        <= '0;
         id_ff         <= '0;
         ep_ff         <= '0;
      end else if (step) begin
         in_payload_ff <= in_payload_in;
         count_ff      <= count_in;
         len_ff        <= len_in;
         id_ff         <= id_in;
         ep_ff         <= ep_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Command frame deframer output stage
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load_valid,
   input  wire cfd_pkg::rsp_type load_data,
   output logic                  advance,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cfd_pkg::rsp_type      rsp_data
);
   import cfd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/command_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// Command frame deframer
// Splits a received byte stream into checked headers and indexed payload.
// ----------------------------------------------------------------------------
// Each received byte gives exactly one result. The block takes one byte per
// cycle while results are taken; a transferred byte is first held in the
// input register, and the header check, length decode and byte counter sit
// between it and the result register that drives the result port.
// Back-pressure on the result side stalls the input only once both registers
// are full. The own endpoint register resets to 2 and is compared on every
// accepted header and on every payload result.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_deframer_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [cfd_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [cfd_pkg::KIND_W-1:0]      rsp_kind,
   output logic [cfd_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [cfd_pkg::ID_W-1:0]        rsp_frame_id,
   output logic [cfd_pkg::EP_W-1:0]        rsp_frame_endpoint,
   output logic [cfd_pkg::LEN_W-1:0]       rsp_payload_length,
   output logic [cfd_pkg::IDX_W-1:0]       rsp_byte_index,
   output logic                            rsp_last,
   output logic                            rsp_for_us,
   input  wire logic                       csr_wr_en,
   input  wire logic [cfd_pkg::EP_W-1:0]   csr_wr_data
);
   import cfd_pkg::*;

   logic [EP_W-1:0]   own_endpoint_ff;
   logic              advance;
   logic              s1_valid;
   logic [BYTE_W-1:0] s1_byte;
   rsp_type           dec_rsp;
   rsp_type           out_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_endpoint_ff <= OWN_EP_RESET;
      end else if (csr_wr_en) begin
         own_endpoint_ff <= csr_wr_data;
      end
   end

   cfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .s1_valid    (s1_valid),
      .s1_byte     (s1_byte)
   );

   cfd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_valid && advance),
      .rx_byte      (s1_byte),
      .own_endpoint (own_endpoint_ff),
      .rsp          (dec_rsp)
   );

   cfd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid),
      .load_data  (dec_rsp),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (out_rsp)
   );

   assign rsp_kind           = out_rsp.kind;
   assign rsp_payload_byte   = out_rsp.payload_byte;
   assign rsp_frame_id       = out_rsp.frame_id;
   assign rsp_frame_endpoint = out_rsp.frame_endpoint;
   assign rsp_payload_length = out_rsp.payload_length;
   assign rsp_byte_index     = out_rsp.byte_index;
   assign rsp_last           = out_rsp.last;
   assign rsp_for_us         = out_rsp.for_us;

endmodule

`default_nettype wire

// ===== verif/deframe_checker.sv =====
// ----------------------------------------------------------------------------
// Command frame deframer checker
// Watches the byte, result and register ports of the deframer, predicts each
// result from the accepted bytes and compares every result transfer with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deframe_checker
   import cfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [KIND_W-1:0]   rsp_kind,
   input  logic [BYTE_W-1:0]   rsp_payload_byte,
   input  logic [ID_W-1:0]     rsp_frame_id,
   input  logic [EP_W-1:0]     rsp_frame_endpoint,
   input  logic [LEN_W-1:0]    rsp_payload_length,
   input  logic [IDX_W-1:0]    rsp_byte_index,
   input  logic                rsp_last,
   input  logic                rsp_for_us,
   input  logic                csr_wr_en,
   input  logic [EP_W-1:0]     csr_wr_data,
   output int                  mismatch_count,
   output int                  outstanding,
   output int                  hdr_ok_count,
   output int                  hdr_bad_count,
   output int                  payload_count,
   output int                  frames_done,
   output int                  frames_for_us
);

   logic             in_frame;
   logic [IDX_W-1:0] rx_count;
   logic [LEN_W-1:0] frame_len;
   logic [ID_W-1:0]  frame_id;
   logic [EP_W-1:0]  frame_ep;
   logic [EP_W-1:0]  own_ep;
   rsp_type          predicted_rsp[$];
   int               rsp_seen;

   function automatic logic [LEN_W-1:0] frame_length(input logic [1:0] code);
      logic [LEN_W-1:0] len;
      case (code)
         2'd0: len = 8'd1;
         2'd1: len = 8'd4;
         2'd2: len = 8'd32;
         default: len = MAX_PAYLOAD;
      endcase
      return len;
   endfunction

   function automatic rsp_type deframe_byte(input logic [BYTE_W-1:0] rx);
      rsp_type r;
      logic    at_end;
      r = '0;
      if (!in_frame) begin
         if ((rx & HDR_VERSION_MASK) != '0 || (rx & HDR_RESERVED_MASK) != '0) begin
            r.kind = KIND_HDR_BAD;
            hdr_bad_count++;
            return r;
         end
         frame_id  = rx[6:5];
         frame_ep  = rx[4:3];
         frame_len = frame_length(rx[1:0]);
         rx_count  = '0;
         in_frame  = 1'b1;
         r.kind           = KIND_HDR_OK;
         r.frame_id       = frame_id;
         r.frame_endpoint = frame_ep;
         r.payload_length = frame_len;
         r.for_us         = (frame_ep == own_ep);
         hdr_ok_count++;
         return r;
      end
      at_end = ({1'b0, rx_count} + 8'd1) >= frame_len;
      r.kind           = KIND_PAYLOAD;
      r.payload_byte   = rx;
      r.frame_id       = frame_id;
      r.frame_endpoint = frame_ep;
      r.payload_length = frame_len;
      r.byte_index     = rx_count;
      r.last           = at_end;
      r.for_us         = (frame_ep == own_ep);
      payload_count++;
      if (at_end) begin
         in_frame = 1'b0;
         rx_count = '0;
         frames_done++;
         if (r.for_us) begin
            frames_for_us++;
         end
      end else begin
         rx_count = rx_count + 1'b1;
      end
      return r;
   endfunction

   task automatic report_fault(input string msg);
      $display("[%0t] deframer check: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         report_fault($sformatf("result %0d %s: expected %0d, got %0d",
                                rsp_seen, name, want, got));
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         in_frame  = 1'b0;
         rx_count  = '0;
         frame_len = '0;
         frame_id  = '0;
         frame_ep  = '0;
         own_ep    = OWN_EP_RESET;
         predicted_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               report_fault($sformatf("result %0d arrived with none outstanding",
                                      rsp_seen));
            end else begin
               want = predicted_rsp.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("frame_id", want.frame_id, rsp_frame_id);
               check_field("frame_endpoint", want.frame_endpoint, rsp_frame_endpoint);
               check_field("payload_length", want.payload_length, rsp_payload_length);
               check_field("byte_index", want.byte_index, rsp_byte_index);
               check_field("last", want.last, rsp_last);
               check_field("for_us", want.for_us, rsp_for_us);
            end
            rsp_seen++;
         end
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(deframe_byte(req_rx_byte));
         end
         if (csr_wr_en) begin
            own_ep = csr_wr_data;
         end
      end
      outstanding <= predicted_rsp.size();
   end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Command frame deframer testbench
// Feeds the deframer directed headers and payload, then random frames mixed
// with malformed headers, under random gaps and result stalls, and changes
// the own endpoint between bursts. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import cfd_pkg::*;

   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASES       = 8;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_ready   = 1'b0;
   logic                csr_wr_en   = 1'b0;
   logic [EP_W-1:0]     csr_wr_data = '0;

   logic                req_ready;
   logic                rsp_valid;
   logic [KIND_W-1:0]   rsp_kind;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic [ID_W-1:0]     rsp_frame_id;
   logic [EP_W-1:0]     rsp_frame_endpoint;
   logic [LEN_W-1:0]    rsp_payload_length;
   logic [IDX_W-1:0]    rsp_byte_index;
   logic                rsp_last;
   logic                rsp_for_us;

   int mismatch_count;
   int outstanding;
   int hdr_ok_count;
   int hdr_bad_count;
   int payload_count;
   int frames_done;
   int frames_for_us;

   int   bytes_sent;
   int   ep_writes;
   logic steady_send;

   command_frame_deframer_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_frame_endpoint (rsp_frame_endpoint),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last           (rsp_last),
      .rsp_for_us         (rsp_for_us),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   deframe_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_frame_endpoint (rsp_frame_endpoint),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last           (rsp_last),
      .rsp_for_us         (rsp_for_us),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding),
      .hdr_ok_count       (hdr_ok_count),
      .hdr_bad_count      (hdr_bad_count),
      .payload_count      (payload_count),
      .frames_done        (frames_done),
      .frames_for_us      (frames_for_us)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d results outstanding.", outstanding);
      $display("tb NOT OK");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // The result side alternates ready runs with stalls; now and then it stays
   // ready for a long stretch.
   initial begin : result_sink
      int run;
      int stall;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 16);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Holds the sender off until every predicted result has been transferred.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_ep(input logic [EP_W-1:0] ep);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ep;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ep_writes++;
   endtask

   task automatic send_frame();
      logic [1:0] code;
      int         r;
      int         len;
      r = $urandom_range(0, 99);
      code = (r < 30) ? 2'd0 : (r < 60) ? 2'd1 : (r < 88) ? 2'd2 : 2'd3;
      case (code)
         2'd0: len = 1;
         2'd1: len = 4;
         2'd2: len = 32;
         default: len = 128;
      endcase
      send_byte({1'b0, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0, code});
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_bad_header();
      logic [BYTE_W-1:0] b;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) begin
         b = b | HDR_VERSION_MASK;
      end else begin
         b = b | HDR_RESERVED_MASK;
      end
      send_byte(b);
   endtask

   initial begin : stimulus
      int phase_start;
      steady_send = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Rejected headers: version bit, reserved bit, both.
      send_byte(8'h80);
      send_byte(8'h04);
      send_byte(8'hFF);
      // Smallest frames, one for another endpoint and one for the own one,
      // with payload bytes that would fail a header check.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h70);
      send_byte(8'h80);
      // Four byte frame to the own endpoint.
      send_byte(8'h11);
      send_byte(8'h04);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h5A);
      // Own endpoint moved to the frame's endpoint halfway through a frame.
      send_byte(8'h49);
      send_byte(8'hFF);
      send_byte(8'h01);
      drain_results();
      write_own_ep(2'd1);
      send_byte(8'h7E);
      send_byte(8'h81);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_own_ep((phase < 6) ? 2'(phase * 3) : 2'($urandom_range(0, 3)));
         steady_send = (phase % 3 == 2);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 99) < 15) begin
               send_bad_header();
            end else begin
               send_frame();
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes: %0d headers accepted, %0d rejected, %0d payload bytes.",
               bytes_sent, hdr_ok_count, hdr_bad_count, payload_count);
      $display("Completed %0d frames, %0d addressed to the own endpoint; %0d endpoint writes.",
               frames_done, frames_for_us, ep_writes);
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
